// ===== rtl/epoch_to_bcd_time_macros.svh =====
// assertion macros for the epoch to bcd time converter
`ifndef EPOCH_TO_BCD_TIME_MACROS_SVH
`define EPOCH_TO_BCD_TIME_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define ETB_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("etb: same-cycle check failed");

// next-cycle implication, sampled on clk, off during reset
`define ETB_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("etb: next-cycle check failed");

`endif

// ===== rtl/etb_pkg.sv =====
// shared widths, calendar constants and helper functions for the epoch converter
package etb_pkg;

	// field widths
	localparam int SECS_W      = 32;
	localparam int SEC_BCD_W   = 7;
	localparam int MIN_BCD_W   = 7;
	localparam int HOUR_BCD_W  = 6;
	localparam int WDAY_W      = 3;
	localparam int DAY_BCD_W   = 6;
	localparam int MON_BCD_W   = 5;
	localparam int YEAR_BCD_W  = 8;

	// seconds count at 2000-01-01 00:00:00
	localparam logic signed [SECS_W-1:0] EPOCH_2000 = 32'sd946684800;

	localparam logic [30:0] SECS_PER_DAY  = 31'd86400;
	localparam logic [13:0] DAYS_PER_QUAD = 14'd1461;
	localparam logic [13:0] DAYS_PER_WEEK = 14'd7;
	// saturday offset for days counted from 2000-01-01
	localparam logic [13:0] WDAY_OFFSET   = 14'd6;
	localparam logic [16:0] SECS_PER_MIN  = 17'd60;
	localparam logic [10:0] MINS_PER_HOUR = 11'd60;

	// year starts inside a leap-first four-year block
	localparam logic [10:0] YEAR1_START = 11'd366;
	localparam logic [10:0] YEAR2_START = 11'd731;
	localparam logic [10:0] YEAR3_START = 11'd1096;

	// reciprocals: q = (x * RCP) >> SH, exact over the operand range used
	localparam logic [24:0] DAY_RCP  = 25'd25451659; // x / 675, x < 2^24
	localparam int          DAY_SH   = 34;
	localparam logic [14:0] QUAD_RCP = 15'd22967;    // x / 1461, x < 2^14
	localparam int          QUAD_SH  = 25;
	localparam logic [14:0] WEEK_RCP = 15'd18725;    // x / 7, x < 2^14
	localparam int          WEEK_SH  = 17;
	localparam logic [17:0] HOUR_RCP = 18'd149131;   // x / 3600, x < 2^17
	localparam int          HOUR_SH  = 29;
	localparam logic [17:0] MIN_RCP  = 18'd139811;   // x / 60, x < 2^17
	localparam int          MIN_SH   = 23;

	// first day of month (0-based day of year)
	function automatic logic [8:0] month_start(input logic [3:0] mon, input logic leap);
		logic [8:0] base;
		case (mon)
			4'd1:    base = 9'd0;
			4'd2:    base = 9'd31;
			4'd3:    base = 9'd59;
			4'd4:    base = 9'd90;
			4'd5:    base = 9'd120;
			4'd6:    base = 9'd151;
			4'd7:    base = 9'd181;
			4'd8:    base = 9'd212;
			4'd9:    base = 9'd243;
			4'd10:   base = 9'd273;
			4'd11:   base = 9'd304;
			4'd12:   base = 9'd334;
			default: base = 9'd0;
		endcase
		if (leap && (mon inside {[4'd3:4'd12]})) begin
			base = base + 9'd1;
		end
		return base;
	endfunction

	// two packed bcd digits of a value below 100
	function automatic logic [7:0] bcd8(input logic [6:0] v);
		logic [17:0] p;
		logic [3:0]  tens;
		logic [6:0]  ones;
		p    = 18'(v) * 18'd205;
		tens = p[14:11];
		ones = v - (7'(tens) * 7'd10);
		return {tens, ones[3:0]};
	endfunction

endpackage

// ===== rtl/etb_if.sv =====
// valid/ready channel interfaces for epoch seconds in and calendar items out
interface etb_in_if;
	import etb_pkg::*;

	logic                     valid;
	logic                     ready;
	logic signed [SECS_W-1:0] epoch_seconds;

	modport source (output valid, output epoch_seconds, input ready);
	modport sink   (input valid, input epoch_seconds, output ready);
endinterface

interface etb_out_if;
	import etb_pkg::*;

	logic                  valid;
	logic                  ready;
	logic                  valid_res;
	logic [SEC_BCD_W-1:0]  second_bcd;
	logic [MIN_BCD_W-1:0]  minute_bcd;
	logic [HOUR_BCD_W-1:0] hour_bcd;
	logic [WDAY_W-1:0]     weekday;
	logic [DAY_BCD_W-1:0]  day_bcd;
	logic [MON_BCD_W-1:0]  month_bcd;
	logic [YEAR_BCD_W-1:0] year_bcd;

	modport source (
		output valid, output valid_res, output second_bcd, output minute_bcd,
		output hour_bcd, output weekday, output day_bcd, output month_bcd,
		output year_bcd, input ready
	);
	modport sink (
		input valid, input valid_res, input second_bcd, input minute_bcd,
		input hour_bcd, input weekday, input day_bcd, input month_bcd,
		input year_bcd, output ready
	);
endinterface

// ===== rtl/epoch_to_bcd_time.sv =====
// epoch seconds to bcd time-of-day and calendar date converter, top level
//
// epoch (sink): one item carries a signed 32-bit seconds count since
//   1970-01-01 00:00:00; accepted when epoch.valid and epoch.ready are high.
// calendar (source): one item per accepted input, in order: bcd seconds,
//   minutes, hours, day, month, two-digit year and a 1..7 weekday (sunday=1).
//   valid_res is low, with every other field zero, when the date is outside
//   2000..2099.
// throughput: one item per cycle, sustained, as long as calendar.ready is high.
// latency: six register stages; an accepted item passes through all six before
//   its result shows on calendar. the depth is set by the chain of constant
//   divides (days, four-year block, hours and minutes, month), one multiply
//   deep per stage.
// stall: each stage holds its item while the next one is full and stalled,
//   so the block keeps taking items into empty stages while a result waits;
//   epoch.ready drops only once all six stages hold items.
// reset: arst_n clears every stage's valid bit; no item is in flight after it.
`include "epoch_to_bcd_time_macros.svh"

module epoch_to_bcd_time (
	input  logic       clk,
	input  logic       arst_n,
	etb_in_if.sink     epoch,
	etb_out_if.source  calendar
);
	import etb_pkg::*;

	// stage valid bits and per-stage ready chain
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;
	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4, rdy_s5, rdy_s6;

	assign rdy_s6 = !vld_s6 || calendar.ready;
	assign rdy_s5 = !vld_s5 || rdy_s6;
	assign rdy_s4 = !vld_s4 || rdy_s5;
	assign rdy_s3 = !vld_s3 || rdy_s4;
	assign rdy_s2 = !vld_s2 || rdy_s3;
	assign rdy_s1 = !vld_s1 || rdy_s2;

	assign epoch.ready = rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else begin
			if (rdy_s1) vld_s1 <= epoch.valid;
			if (rdy_s2) vld_s2 <= vld_s1;
			if (rdy_s3) vld_s3 <= vld_s2;
			if (rdy_s4) vld_s4 <= vld_s3;
			if (rdy_s5) vld_s5 <= vld_s4;
			if (rdy_s6) vld_s6 <= vld_s5;
		end
	end

	// stage 1: input register
	logic signed [SECS_W-1:0] sec_s1;

	always_ff @(posedge clk) begin
		if (rdy_s1 && epoch.valid) begin
			sec_s1 <= epoch.epoch_seconds;
		end
	end

	// stage a: rebase to 2000, whole days via 86400 = 128 * 675
	logic signed [SECS_W:0] diff_a;
	logic                   ok_a;
	logic [30:0]            s_a;
	logic [48:0]            prod_a;
	logic [13:0]            days_a;

	always_comb begin
		diff_a = (SECS_W+1)'(sec_s1) - (SECS_W+1)'(EPOCH_2000);
		// anything before 2000 is out of range; the top of the input range is in 2038
		ok_a   = !diff_a[SECS_W];
		s_a    = diff_a[30:0];
		prod_a = 49'(s_a[30:7]) * 49'(DAY_RCP);
		days_a = prod_a[DAY_SH+13:DAY_SH];
	end

	logic [30:0] s_s2;
	logic [13:0] days_s2;
	logic        ok_s2;

	always_ff @(posedge clk) begin
		if (rdy_s2 && vld_s1) begin
			s_s2    <= s_a;
			days_s2 <= days_a;
			ok_s2   <= ok_a;
		end
	end

	// stage b: seconds of day, four-year block index, week quotient
	logic [30:0] rem_b;
	logic [28:0] pq_b;
	logic [13:0] wy_b;
	logic [28:0] pw_b;

	always_comb begin
		rem_b = s_s2 - (31'(days_s2) * SECS_PER_DAY);
		pq_b  = 29'(days_s2) * 29'(QUAD_RCP);
		wy_b  = days_s2 + WDAY_OFFSET;
		pw_b  = 29'(wy_b) * 29'(WEEK_RCP);
	end

	logic [16:0] sod_s3;
	logic [13:0] days_s3;
	logic [3:0]  q4_s3;
	logic [13:0] wy_s3;
	logic [10:0] wq_s3;
	logic        ok_s3;

	always_ff @(posedge clk) begin
		if (rdy_s3 && vld_s2) begin
			sod_s3  <= rem_b[16:0];
			days_s3 <= days_s2;
			q4_s3   <= pq_b[QUAD_SH+3:QUAD_SH];
			wy_s3   <= wy_b;
			wq_s3   <= pw_b[WEEK_SH+10:WEEK_SH];
			ok_s3   <= ok_s2;
		end
	end

	// stage c: hours and total minutes of day, day within block, weekday
	logic [34:0] ph_c;
	logic [34:0] pm_c;
	logic [13:0] r4_c;
	logic [13:0] wr_c;
	logic [2:0]  wd_c;

	always_comb begin
		ph_c = 35'(sod_s3) * 35'(HOUR_RCP);
		pm_c = 35'(sod_s3) * 35'(MIN_RCP);
		r4_c = days_s3 - (14'(q4_s3) * DAYS_PER_QUAD);
		wr_c = wy_s3 - (14'(wq_s3) * DAYS_PER_WEEK);
		wd_c = wr_c[2:0] + 3'd1;
	end

	logic [16:0] sod_s4;
	logic [10:0] tm_s4;
	logic [4:0]  hh_s4;
	logic [10:0] r4_s4;
	logic [3:0]  q4_s4;
	logic [2:0]  wd_s4;
	logic        ok_s4;

	always_ff @(posedge clk) begin
		if (rdy_s4 && vld_s3) begin
			sod_s4 <= sod_s3;
			tm_s4  <= pm_c[MIN_SH+10:MIN_SH];
			hh_s4  <= ph_c[HOUR_SH+4:HOUR_SH];
			r4_s4  <= r4_c[10:0];
			q4_s4  <= q4_s3;
			wd_s4  <= wd_c;
			ok_s4  <= ok_s3;
		end
	end

	// stage d: seconds within minute and minutes within hour, year within block
	logic [16:0] ssr_d;
	logic [10:0] mir_d;
	logic [1:0]  yoff_d;
	logic [10:0] ybase_d;
	logic [10:0] doyr_d;
	logic [5:0]  year_d;

	always_comb begin
		ssr_d = sod_s4 - (17'(tm_s4) * SECS_PER_MIN);
		mir_d = tm_s4 - (11'(hh_s4) * MINS_PER_HOUR);
		// 2000..2099 keep the plain every-fourth-year leap rule
		if (r4_s4 < YEAR1_START) begin
			yoff_d  = 2'd0;
			ybase_d = 11'd0;
		end else if (r4_s4 < YEAR2_START) begin
			yoff_d  = 2'd1;
			ybase_d = YEAR1_START;
		end else if (r4_s4 < YEAR3_START) begin
			yoff_d  = 2'd2;
			ybase_d = YEAR2_START;
		end else begin
			yoff_d  = 2'd3;
			ybase_d = YEAR3_START;
		end
		doyr_d = r4_s4 - ybase_d;
		year_d = {q4_s4, 2'b00} + 6'(yoff_d);
	end

	logic [5:0] ss_s5;
	logic [5:0] mi_s5;
	logic [4:0] hh_s5;
	logic [8:0] doy_s5;
	logic       leap_s5;
	logic [5:0] year_s5;
	logic [2:0] wd_s5;
	logic       ok_s5;

	always_ff @(posedge clk) begin
		if (rdy_s5 && vld_s4) begin
			ss_s5   <= ssr_d[5:0];
			mi_s5   <= mir_d[5:0];
			hh_s5   <= hh_s4;
			doy_s5  <= doyr_d[8:0];
			leap_s5 <= (yoff_d == 2'd0);
			year_s5 <= year_d;
			wd_s5   <= wd_s4;
			ok_s5   <= ok_s4;
		end
	end

	// stage e: month and day of month, bcd packing, out-of-range gating
	logic [3:0] mon_e;
	logic [8:0] domr_e;
	logic [7:0] ss_bcd_e, mi_bcd_e, hh_bcd_e, day_bcd_e, mon_bcd_e, year_bcd_e;

	always_comb begin
		mon_e = 4'd1;
		for (int m = 2; m <= 12; m++) begin
			if (doy_s5 >= month_start(4'(m), leap_s5)) begin
				mon_e = 4'(m);
			end
		end
		domr_e     = doy_s5 - month_start(mon_e, leap_s5) + 9'd1;
		ss_bcd_e   = bcd8({1'b0, ss_s5});
		mi_bcd_e   = bcd8({1'b0, mi_s5});
		hh_bcd_e   = bcd8({2'b00, hh_s5});
		day_bcd_e  = bcd8({2'b00, domr_e[4:0]});
		mon_bcd_e  = bcd8({3'b000, mon_e});
		year_bcd_e = bcd8({1'b0, year_s5});
	end

	// stage 6: result register, drives the calendar channel
	logic                  ok_s6;
	logic [SEC_BCD_W-1:0]  sec_s6;
	logic [MIN_BCD_W-1:0]  min_s6;
	logic [HOUR_BCD_W-1:0] hour_s6;
	logic [WDAY_W-1:0]     wday_s6;
	logic [DAY_BCD_W-1:0]  day_s6;
	logic [MON_BCD_W-1:0]  mon_s6;
	logic [YEAR_BCD_W-1:0] year_s6;

	always_ff @(posedge clk) begin
		if (rdy_s6 && vld_s5) begin
			ok_s6 <= ok_s5;
			if (ok_s5) begin
				sec_s6  <= ss_bcd_e[SEC_BCD_W-1:0];
				min_s6  <= mi_bcd_e[MIN_BCD_W-1:0];
				hour_s6 <= hh_bcd_e[HOUR_BCD_W-1:0];
				wday_s6 <= wd_s5;
				day_s6  <= day_bcd_e[DAY_BCD_W-1:0];
				mon_s6  <= mon_bcd_e[MON_BCD_W-1:0];
				year_s6 <= year_bcd_e;
			end else begin
				sec_s6  <= '0;
				min_s6  <= '0;
				hour_s6 <= '0;
				wday_s6 <= '0;
				day_s6  <= '0;
				mon_s6  <= '0;
				year_s6 <= '0;
			end
		end
	end

	assign calendar.valid      = vld_s6;
	assign calendar.valid_res  = ok_s6;
	assign calendar.second_bcd = sec_s6;
	assign calendar.minute_bcd = min_s6;
	assign calendar.hour_bcd   = hour_s6;
	assign calendar.weekday    = wday_s6;
	assign calendar.day_bcd    = day_s6;
	assign calendar.month_bcd  = mon_s6;
	assign calendar.year_bcd   = year_s6;

	// summary terms for the checks below
	logic res_zero;
	logic res_set;
	logic pipe_full;

	assign res_zero  = ({sec_s6, min_s6, hour_s6, wday_s6, day_s6, mon_s6, year_s6} == '0);
	assign res_set   = (wday_s6 != '0) && (day_s6 != '0) && (mon_s6 != '0);
	assign pipe_full = vld_s1 && vld_s2 && vld_s3 && vld_s4 && vld_s5 && vld_s6;

	// out-of-range results carry all-zero fields
	`ETB_ASSERT_IMP(a_invalid_zero, calendar.valid && !calendar.valid_res, res_zero)
	// in-range results have a real weekday, day and month
	`ETB_ASSERT_IMP(a_valid_fields, calendar.valid && calendar.valid_res, res_set)
	// a full pipeline behind a stalled output takes no item
	`ETB_ASSERT_IMP(a_full_stall, pipe_full && !calendar.ready, !epoch.ready)
	// an accepted item lands in the first stage
	`ETB_ASSERT_NXT(a_accept_loads, epoch.valid && epoch.ready, vld_s1)

endmodule

// ===== bench/tb_epoch_to_bcd_time.sv =====
// self-checking bench for the epoch seconds to bcd calendar converter
module tb_epoch_to_bcd_time;
	import etb_pkg::*;

	// run limit in clock cycles, far beyond the slowest correct run
	localparam int CYCLE_LIMIT = 500000;
	// cycles to linger once every calendar item has come back
	localparam int DRAIN_CYCLES = 12;
	// first day of 2000 and last whole day (counted from 1970-01-01) in the input range
	localparam int FIRST_DAY_2000 = 10957;
	localparam int LAST_WHOLE_DAY = 24854;

	typedef struct packed {
		logic                  valid_res;
		logic [SEC_BCD_W-1:0]  second_bcd;
		logic [MIN_BCD_W-1:0]  minute_bcd;
		logic [HOUR_BCD_W-1:0] hour_bcd;
		logic [WDAY_W-1:0]     weekday;
		logic [DAY_BCD_W-1:0]  day_bcd;
		logic [MON_BCD_W-1:0]  month_bcd;
		logic [YEAR_BCD_W-1:0] year_bcd;
	} calendar_t;

	logic clk;
	logic arst_n;

	etb_in_if  epoch_ch ();
	etb_out_if calendar_ch ();

	epoch_to_bcd_time i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.epoch    (epoch_ch),
		.calendar (calendar_ch)
	);

	// calendar items still owed by the block, oldest first
	calendar_t pending_dates[$];
	int        error_count;
	int        cycle_count;
	// when set, neither side idles: back-to-back items on both channels
	bit        no_idle;

	initial begin
		clk = 1'b0;
	end

	always #1 clk = ~clk;

	// division rounding toward minus infinity
	function automatic longint div_floor(input longint num, input longint den);
		longint q;
		q = num / den;
		if (num - q * den < 0) begin
			q = q - 1;
		end
		return q;
	endfunction

	function automatic logic [7:0] two_digit_bcd(input longint v);
		return 8'(((v / 10) << 4) | (v % 10));
	endfunction

	// civil date and time of day for a signed seconds count
	function automatic calendar_t predict_calendar(input logic signed [SECS_W-1:0] secs);
		calendar_t res;
		longint    s;
		longint    days;
		longint    sod;
		longint    shifted;
		longint    era;
		longint    doe;
		longint    yoe;
		longint    doy;
		longint    mp;
		longint    dom;
		longint    mon;
		longint    yr;
		longint    wd;
		s    = secs;
		// a negative remainder borrows one day
		days = div_floor(s, 86400);
		sod  = s - days * 86400;
		// march-based years inside 400-year eras
		shifted = days + 719468;
		era     = div_floor(shifted, 146097);
		doe     = shifted - era * 146097;
		yoe     = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
		yr      = yoe + era * 400;
		doy     = doe - (365 * yoe + yoe / 4 - yoe / 100);
		mp      = (5 * doy + 2) / 153;
		dom     = doy - (153 * mp + 2) / 5 + 1;
		mon     = (mp < 10) ? mp + 3 : mp - 9;
		if (mon <= 2) begin
			yr = yr + 1;
		end
		// 1970-01-01 was a thursday
		wd = (days + 4) % 7;
		if (wd < 0) begin
			wd = wd + 7;
		end
		res = '0;
		// only two bcd year digits, so anything outside the century is all zero
		if (yr >= 2000 && yr <= 2099) begin
			res.valid_res  = 1'b1;
			res.second_bcd = SEC_BCD_W'(two_digit_bcd(sod % 60));
			res.minute_bcd = MIN_BCD_W'(two_digit_bcd((sod % 3600) / 60));
			res.hour_bcd   = HOUR_BCD_W'(two_digit_bcd(sod / 3600));
			res.weekday    = WDAY_W'(wd + 1);
			res.day_bcd    = DAY_BCD_W'(two_digit_bcd(dom));
			res.month_bcd  = MON_BCD_W'(two_digit_bcd(mon));
			res.year_bcd   = two_digit_bcd(yr - 2000);
		end
		return res;
	endfunction

	// offer one seconds count and hold it until the block takes it
	task automatic send_epoch(input logic signed [SECS_W-1:0] secs);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 14);
		if (gap > 0) begin
			epoch_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		epoch_ch.valid         <= 1'b1;
		epoch_ch.epoch_seconds <= secs;
		do begin
			@(posedge clk);
		end while (!epoch_ch.ready);
		pending_dates.push_back(predict_calendar(secs));
	endtask

	// hold off new items until the block has handed back everything
	task automatic wait_all_returned();
		epoch_ch.valid <= 1'b0;
		while (pending_dates.size() != 0) begin
			@(posedge clk);
		end
	endtask

	// extremes of the input word and the day borrow around the epoch
	task automatic test_input_extremes();
		send_epoch(32'sd0);
		send_epoch(-32'sd1);
		send_epoch(32'sd1);
		send_epoch(32'sh7fffffff);
		send_epoch(32'sh80000000);
		send_epoch(32'sh80000001);
		send_epoch(-32'sd86400);
		send_epoch(-32'sd86401);
		send_epoch(32'sd86399);
		send_epoch(32'sd86400);
		send_epoch(32'shffffffff ^ 32'sh7fffffff);
		send_epoch(32'sh55555555);
		send_epoch(32'shaaaaaaaa);
	endtask

	// century edge, leap days and the last second of a day and a year
	task automatic test_calendar_edges();
		send_epoch(EPOCH_2000 - 32'sd1);
		send_epoch(EPOCH_2000);
		send_epoch(EPOCH_2000 + 32'sd1);
		send_epoch(32'sd951782399);  // 2000-02-28 23:59:59
		send_epoch(32'sd951782400);  // 2000-02-29, leap day of a 400-year
		send_epoch(32'sd951868800);  // 2000-03-01
		send_epoch(32'sd978307199);  // 2000-12-31 23:59:59
		send_epoch(32'sd978307200);  // 2001-01-01
		send_epoch(32'sd1078012800); // 2004-02-29
		send_epoch(32'sd1609459199); // 2020-12-31 23:59:59
	endtask

	// random seconds: mostly inside the century, some anywhere, some near midnight
	task automatic test_random_dates(input int count);
		logic signed [SECS_W-1:0] secs;
		longint                   near_midnight;
		int                       pick;
		for (int i = 0; i < count; i++) begin
			// every fourth stretch of 100 items runs without idling
			no_idle = ((i / 100) % 4) == 3;
			pick = $urandom_range(0, 9);
			if (pick <= 5) begin
				secs = $urandom_range(946684800, 2147483647);
			end else if (pick <= 7) begin
				secs = $urandom();
			end else begin
				near_midnight = longint'($urandom_range(FIRST_DAY_2000, LAST_WHOLE_DAY)) * 86400
					+ $urandom_range(0, 4) - 2;
				secs = near_midnight[SECS_W-1:0];
			end
			send_epoch(secs);
		end
		no_idle = 1'b0;
	endtask

	// a solid burst with both sides always willing
	task automatic test_back_to_back(input int count);
		no_idle = 1'b1;
		for (int i = 0; i < count; i++) begin
			send_epoch($urandom_range(946684800, 2147483647));
		end
		no_idle = 1'b0;
	endtask

	// receiver: a random stall before each calendar item
	initial begin
		int gap;
		calendar_ch.ready <= 1'b0;
		wait (arst_n);
		forever begin
			gap = no_idle ? 0 : $urandom_range(0, 14);
			if (gap > 0) begin
				calendar_ch.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			calendar_ch.ready <= 1'b1;
			do begin
				@(posedge clk);
			end while (!(calendar_ch.valid && calendar_ch.ready));
		end
	end

	// compare each returned item with the oldest prediction
	always @(posedge clk) begin
		calendar_t want;
		if (arst_n && calendar_ch.valid && calendar_ch.ready) begin
			if (pending_dates.size() == 0) begin
				$error("calendar item with nothing outstanding");
				error_count++;
			end else begin
				want = pending_dates.pop_front();
				if (calendar_ch.valid_res !== want.valid_res) begin
					$error("valid_res: expected %0h, got %0h", want.valid_res,
						calendar_ch.valid_res);
					error_count++;
				end
				if (calendar_ch.second_bcd !== want.second_bcd) begin
					$error("second_bcd: expected %0h, got %0h", want.second_bcd,
						calendar_ch.second_bcd);
					error_count++;
				end
				if (calendar_ch.minute_bcd !== want.minute_bcd) begin
					$error("minute_bcd: expected %0h, got %0h", want.minute_bcd,
						calendar_ch.minute_bcd);
					error_count++;
				end
				if (calendar_ch.hour_bcd !== want.hour_bcd) begin
					$error("hour_bcd: expected %0h, got %0h", want.hour_bcd,
						calendar_ch.hour_bcd);
					error_count++;
				end
				if (calendar_ch.weekday !== want.weekday) begin
					$error("weekday: expected %0h, got %0h", want.weekday,
						calendar_ch.weekday);
					error_count++;
				end
				if (calendar_ch.day_bcd !== want.day_bcd) begin
					$error("day_bcd: expected %0h, got %0h", want.day_bcd,
						calendar_ch.day_bcd);
					error_count++;
				end
				if (calendar_ch.month_bcd !== want.month_bcd) begin
					$error("month_bcd: expected %0h, got %0h", want.month_bcd,
						calendar_ch.month_bcd);
					error_count++;
				end
				if (calendar_ch.year_bcd !== want.year_bcd) begin
					$error("year_bcd: expected %0h, got %0h", want.year_bcd,
						calendar_ch.year_bcd);
					error_count++;
				end
			end
		end
	end

	// watchdog: a hung handshake ends the run as a failure
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin
		error_count = 0;
		cycle_count = 0;
		no_idle     = 1'b0;
		arst_n                 <= 1'b0;
		epoch_ch.valid         <= 1'b0;
		epoch_ch.epoch_seconds <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_input_extremes();
		// sender pauses here until the pipeline is empty
		wait_all_returned();
		test_calendar_edges();
		test_random_dates(1700);
		test_back_to_back(230);

		// let everything drain, then wait DRAIN_CYCLES longer for stray items
		wait_all_returned();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
